[hdl/plic_pkg.sv]
// plic_pkg: shared constants, types and codes for the posting list intersection core
// no dependencies; imported by every other file of the block except plic_ram

package plic_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int RIDX_W   = 6;
  localparam int SURV_W   = 7;

  typedef enum logic [0:0] {
    OP_ELEMENT = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [SURV_W-1:0] survivor_count;
    logic [ID_W-1:0]   read_file_id;
    logic              read_valid;
    logic              overflow;
  } result_t;

endpackage

[hdl/plic_in_if.sv]
// plic_in_if: input channel, valid/ready handshake with the item fields
// depends on plic_pkg

interface plic_in_if
  import plic_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [0:0]        operation;
  logic [ID_W-1:0]   file_id;
  logic              has_element;
  logic              list_start;
  logic              list_end;
  logic              initial_list;
  logic [RIDX_W-1:0] read_index;

  modport source (
    output valid, operation, file_id, has_element, list_start, list_end,
           initial_list, read_index,
    input  ready
  );

  modport sink (
    input  valid, operation, file_id, has_element, list_start, list_end,
           initial_list, read_index,
    output ready
  );
endinterface

[hdl/plic_out_if.sv]
// plic_out_if: result channel, valid/ready handshake with the result fields
// depends on plic_pkg

interface plic_out_if
  import plic_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SURV_W-1:0] survivor_count;
  logic [ID_W-1:0]   read_file_id;
  logic              read_valid;
  logic              overflow;

  modport source (
    output valid, survivor_count, read_file_id, read_valid, overflow,
    input  ready
  );

  modport sink (
    input  valid, survivor_count, read_file_id, read_valid, overflow,
    output ready
  );
endinterface

[hdl/plic_ram.sv]
// plic_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module plic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/plic_seq.sv]
// plic_seq: sequencer with scan/write pointers and the shared compare step
// depends on plic_pkg and plic_in_if; drives the candidate ram through a request struct

module plic_seq
  import plic_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  plic_in_if.sink         in_ch,
  output ram_req_t        ram_req,
  input  logic [ID_W-1:0] ram_rdata,
  output logic            res_valid,
  input  logic            res_take,
  output result_t         res
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  scan_pointer, scan_pointer_next;
  logic [CNT_W-1:0]  write_pointer, write_pointer_next;
  logic [CNT_W-1:0]  candidate_count, candidate_count_next;
  logic              overflow_flag, overflow_flag_next;
  logic [ID_W-1:0]   key, key_next;
  logic              end_pending, end_pending_next;
  logic              rd_ok, rd_ok_next;

  logic              accept;
  logic              is_read;
  logic [CNT_W-1:0]  sp_eff;
  logic [CNT_W-1:0]  wp_eff;
  logic [CNT_W-1:0]  sp_inc;
  logic              cand_lt;
  logic              cand_eq;
  logic              scan_more;
  logic              merge_go;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_read     = (in_ch.operation == OP_READ);
  assign sp_eff      = in_ch.list_start ? '0 : scan_pointer;
  assign wp_eff      = in_ch.list_start ? '0 : write_pointer;
  assign merge_go    = accept && !is_read && in_ch.has_element && !in_ch.initial_list
                       && (sp_eff < candidate_count);

  // shared compare of the addressed candidate against the held element
  assign cand_lt     = ram_rdata < key;
  assign cand_eq     = ram_rdata == key;
  assign sp_inc      = scan_pointer + CNT_W'(1);
  assign scan_more   = cand_lt && (sp_inc < candidate_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = merge_go ? ST_MERGE : ST_EMIT;
        end
      end
      ST_MERGE: begin
        state_next = scan_more ? ST_MERGE : ST_EMIT;
      end
      ST_EMIT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    scan_pointer_next    = scan_pointer;
    write_pointer_next   = write_pointer;
    candidate_count_next = candidate_count;
    overflow_flag_next   = overflow_flag;
    key_next             = key;
    end_pending_next     = end_pending;
    rd_ok_next           = rd_ok;
    ram_req              = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_read) begin
            ram_req.re       = 1'b1;
            ram_req.raddr    = ADDR_W'(in_ch.read_index);
            rd_ok_next       = CNT_W'(in_ch.read_index) < candidate_count;
            end_pending_next = 1'b0;
          end else begin
            rd_ok_next         = 1'b0;
            end_pending_next   = in_ch.list_end;
            scan_pointer_next  = sp_eff;
            write_pointer_next = wp_eff;
            key_next           = in_ch.file_id;
            if (in_ch.has_element) begin
              if (in_ch.initial_list) begin
                if (wp_eff < CNT_W'(CAPACITY)) begin
                  ram_req.we         = 1'b1;
                  ram_req.waddr      = wp_eff[ADDR_W-1:0];
                  ram_req.wdata      = in_ch.file_id;
                  write_pointer_next = wp_eff + CNT_W'(1);
                end else begin
                  overflow_flag_next = 1'b1;
                end
              end else if (merge_go) begin
                ram_req.re    = 1'b1;
                ram_req.raddr = sp_eff[ADDR_W-1:0];
              end
            end
          end
        end
      end
      ST_MERGE: begin
        if (cand_lt) begin
          scan_pointer_next = sp_inc;
          if (scan_more) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = sp_inc[ADDR_W-1:0];
          end
        end else if (cand_eq) begin
          scan_pointer_next = sp_inc;
          if (write_pointer < CNT_W'(CAPACITY)) begin
            ram_req.we         = 1'b1;
            ram_req.waddr      = write_pointer[ADDR_W-1:0];
            ram_req.wdata      = ram_rdata;
            write_pointer_next = write_pointer + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (res_take && end_pending) begin
          candidate_count_next = write_pointer;
        end
      end
      default: ;
    endcase
  end

  assign res_valid          = (state == ST_EMIT);
  assign res.survivor_count = SURV_W'(end_pending ? write_pointer : candidate_count);
  assign res.read_file_id   = rd_ok ? ram_rdata : '0;
  assign res.read_valid     = rd_ok;
  assign res.overflow       = overflow_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      scan_pointer    <= '0;
      write_pointer   <= '0;
      candidate_count <= '0;
      overflow_flag   <= 1'b0;
      end_pending     <= 1'b0;
      rd_ok           <= 1'b0;
    end else begin
      state           <= state_next;
      scan_pointer    <= scan_pointer_next;
      write_pointer   <= write_pointer_next;
      candidate_count <= candidate_count_next;
      overflow_flag   <= overflow_flag_next;
      end_pending     <= end_pending_next;
      rd_ok           <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

[hdl/posting_list_intersection_core.sv]
// posting_list_intersection_core: top level, candidate ram, sequencer and result register
// depends on plic_pkg, plic_in_if, plic_out_if, plic_ram and plic_seq
//
// usage
//   in_ch  : one word per item; operation selects a posting list element or a read
//            of a surviving candidate by read_index
//   out_ch : exactly one result word per input word, in order: survivor count,
//            read-back candidate with its valid bit, sticky overflow
//   the first list (initial_list set) is written straight into a 64-entry
//   candidate ram; later lists are merged against it, matches compacted in place
// timing
//   in_ch.ready is high only while the sequencer is idle, one item at a time
//   a read, an initial-list element or an element that finds the scan finished
//   goes from idle straight to the result step; a merge element first walks the
//   stored candidates its compare visits (one ram read and compare per cycle)
//   the result step loads the output register as soon as that register is free
// reset and stall
//   rst (synchronous, active high) clears counts, pointers and overflow; ram
//   contents stay undefined until written, nothing needs clearing
//   a stalled out_ch holds its word; the core still takes the next item and
//   waits on its own result step until the output register frees up

module posting_list_intersection_core
  import plic_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  plic_in_if.sink  in_ch,
  plic_out_if.source out_ch
);

  ram_req_t        ram_req;
  logic [ID_W-1:0] ram_rdata;
  logic            res_valid;
  logic            res_take;
  result_t         res;

  // output register state
  logic            out_valid;
  result_t         out_word;

  plic_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  plic_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // slot is free when empty or being drained this cycle
  assign res_take = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_word <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.survivor_count = out_word.survivor_count;
  assign out_ch.read_file_id   = out_word.read_file_id;
  assign out_ch.read_valid     = out_word.read_valid;
  assign out_ch.overflow       = out_word.overflow;

endmodule

[sim/plic_tb_pkg.sv]
// plic_tb_pkg: input word type and the intersection scoreboard for the core testbench
// depends on plic_pkg; imported by tb_posting_list_intersection_core

package plic_tb_pkg;
  import plic_pkg::*;

  typedef struct {
    op_t               operation;
    logic [ID_W-1:0]   file_id;
    logic              has_element;
    logic              list_start;
    logic              list_end;
    logic              initial_list;
    logic [RIDX_W-1:0] read_index;
  } item_t;

  class intersection_scoreboard;
    logic [ID_W-1:0] candidates [CAPACITY];
    int              survivors;
    int              scan_ptr;
    int              write_ptr;
    bit              overflow_seen;
    int              filled;
    int              peak_survivors;
    result_t         results_due [$];
    int              errors;
    int              checked;
    int              reads_hit;

    function new();
      foreach (candidates[i]) candidates[i] = '0;
      survivors      = 0;
      scan_ptr       = 0;
      write_ptr      = 0;
      overflow_seen  = 1'b0;
      filled         = 0;
      peak_survivors = 0;
      errors         = 0;
      checked        = 0;
      reads_hit      = 0;
    endfunction

    // skip smaller candidates, compact an equal one down to the write pointer
    function void merge_id(logic [ID_W-1:0] id);
      while (scan_ptr < survivors && candidates[scan_ptr] < id) scan_ptr++;
      if (scan_ptr < survivors && candidates[scan_ptr] == id) begin
        if (write_ptr < CAPACITY) begin
          candidates[write_ptr] = candidates[scan_ptr];
          write_ptr++;
        end
        scan_ptr++;
      end
    endfunction

    function result_t apply_item(item_t it);
      result_t r;
      r = '0;
      if (it.operation == OP_READ) begin
        if (it.read_index < survivors) begin
          r.read_file_id = candidates[it.read_index];
          r.read_valid   = 1'b1;
        end
      end else begin
        if (it.list_start) begin
          scan_ptr  = 0;
          write_ptr = 0;
        end
        if (it.has_element) begin
          if (it.initial_list) begin
            if (write_ptr < CAPACITY) begin
              candidates[write_ptr] = it.file_id;
              write_ptr++;
            end else begin
              overflow_seen = 1'b1;
            end
          end else begin
            merge_id(it.file_id);
          end
        end
        if (it.list_end) survivors = write_ptr;
        if (write_ptr > filled) filled = write_ptr;
        if (survivors > peak_survivors) peak_survivors = survivors;
      end
      r.survivor_count = SURV_W'(survivors);
      r.overflow       = overflow_seen;
      return r;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void note_item(item_t it);
      results_due.insert(results_due.size(), apply_item(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result word: count %0d id %h valid %b ovf %b",
                         got.survivor_count, got.read_file_id, got.read_valid, got.overflow));
        return;
      end
      want = results_due.pop_front();
      checked++;
      if (want.read_valid) reads_hit++;
      if (got.survivor_count !== want.survivor_count || got.read_file_id !== want.read_file_id ||
          got.read_valid !== want.read_valid || got.overflow !== want.overflow)
        report($sformatf({"mismatch on result %0d: count exp %0d got %0d, id exp %h got %h, ",
                          "valid exp %b got %b, ovf exp %b got %b"}, checked,
                         want.survivor_count, got.survivor_count, want.read_file_id,
                         got.read_file_id, want.read_valid, got.read_valid,
                         want.overflow, got.overflow));
    endfunction

    function void drain_check();
      if (results_due.size() != 0)
        report($sformatf("%0d result words never arrived", results_due.size()));
    endfunction
  endclass

endpackage

[sim/tb_posting_list_intersection_core.sv]
// tb_posting_list_intersection_core: drives posting lists and read-backs into the core
// and checks every result word against the scoreboard in plic_tb_pkg
// depends on plic_pkg, plic_in_if, plic_out_if, plic_tb_pkg and the core itself

module tb_posting_list_intersection_core
  import plic_pkg::*;
  import plic_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 10;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int TAIL_CYCLES     = 100;
  localparam int PHASE_ITEMS     = 440;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;

  plic_in_if  in_ch ();
  plic_out_if out_ch ();

  posting_list_intersection_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  intersection_scoreboard sb = new();

  // knobs shared between the stimulus and the result-side process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int lists_sent     = 0;

  always #(CLK_HALF) clk = ~clk;

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------

  function automatic item_t element(logic [ID_W-1:0] id, bit has, bit start, bit fin,
                                    bit init);
    item_t it;
    it.operation    = OP_ELEMENT;
    it.file_id      = id;
    it.has_element  = has;
    it.list_start   = start;
    it.list_end     = fin;
    it.initial_list = init;
    it.read_index   = RIDX_W'($urandom_range(63));
    return it;
  endfunction

  // the list flags and id ride along on a read but must be ignored by the core
  function automatic item_t read_word(logic [RIDX_W-1:0] idx);
    item_t it;
    it = element($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
    it.operation  = OP_READ;
    it.read_index = idx;
    return it;
  endfunction

  // mostly full-range ids, now and then the two extremes
  function automatic logic [ID_W-1:0] random_id();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // read indexes stay inside the part of the ram that has been written at least once;
  // most land below the survivor count so that real data comes back
  function automatic logic [RIDX_W-1:0] pick_index();
    if (sb.survivors > 0 && $urandom_range(9) < 7)
      return RIDX_W'($urandom_range(sb.survivors - 1));
    if (sb.filled >= CAPACITY) return RIDX_W'($urandom_range(CAPACITY - 1));
    return RIDX_W'($urandom_range(sb.filled - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // random gap first, then hold the word until the core takes it; valid is left
  // high on return so that a back-to-back word needs no second assignment
  task automatic send_word(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= it.operation;
    in_ch.file_id      <= it.file_id;
    in_ch.has_element  <= it.has_element;
    in_ch.list_start   <= it.list_start;
    in_ch.list_end     <= it.list_end;
    in_ch.initial_list <= it.initial_list;
    in_ch.read_index   <= it.read_index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // sender pause: drop valid and wait for every outstanding result word
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
  endtask

  // a well-formed list: start on the first word, end on the last, or now and then
  // the end carried by a separate word with no element; an empty list is one marker
  task automatic send_list(input bit init_mode, input logic [ID_W-1:0] ids [$]);
    int n;
    bit split_end;
    n         = ids.size();
    split_end = ($urandom_range(9) == 0);
    lists_sent++;
    if (n == 0) begin
      send_word(element($urandom, 1'b0, 1'b1, 1'b1, init_mode));
    end else begin
      for (int i = 0; i < n; i++)
        send_word(element(ids[i], 1'b1, i == 0, (i == n - 1) && !split_end, init_mode));
      if (split_end)
        send_word(element($urandom, 1'b0, 1'b0, 1'b1, 1'($urandom_range(1))));
    end
  endtask

  task automatic send_initial_list(input int n);
    logic [ID_W-1:0] ids [$];
    for (int i = 0; i < n; i++) ids.insert(ids.size(), random_id());
    ids.sort();
    send_list(1'b1, ids);
  endtask

  // built from the current survivors so that the merge finds matches, with a few
  // strangers mixed in and sometimes a tail past the last candidate
  task automatic send_merge_list();
    logic [ID_W-1:0] ids [$];
    for (int i = 0; i < sb.survivors; i++)
      if ($urandom_range(99) < 65) ids.insert(ids.size(), sb.candidates[i]);
    repeat ($urandom_range(4)) ids.insert(ids.size(), random_id());
    if ($urandom_range(4) == 0) begin
      ids.insert(ids.size(), '1);
      ids.insert(ids.size(), '1);
    end
    ids.sort();
    send_list(1'b0, ids);
  endtask

  // broken input: every flag random, so missing starts, mixed modes and unsorted ids
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_word(element(random_id(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  // ---------------------------------------------------------------------------
  // directed opening
  // ---------------------------------------------------------------------------

  task automatic run_directed();
    // loaded list spanning the whole id range
    send_word(element(32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b1));
    send_word(element(32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(element(32'h0000_0005, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(element(32'h0000_0009, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(element(32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1));
    send_word(element(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1));
    // merge keeps 3, 9 and the top id; 4 falls between candidates
    send_word(element(32'h0000_0003, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(element(32'h0000_0004, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(element(32'h0000_0009, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(element(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0));
    // read back the first and last survivor, then one just past the count
    send_word(read_word(0));
    send_word(read_word(2));
    send_word(read_word(3));
    // the top id matches after skipping; its repeat finds the scan exhausted;
    // the list is closed by an end marker without an element
    send_word(element(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0));
    send_word(element(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
    send_word(element(32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0));
    send_word(read_word(0));
    // empty intersected list wipes every survivor
    send_word(element(32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b0));
    send_word(read_word(0));
  endtask

  // ---------------------------------------------------------------------------
  // random phases
  // ---------------------------------------------------------------------------

  task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
    int phase_end;
    int pick;
    int len_pick;
    bit held;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    phase_end      = items_sent + PHASE_ITEMS;
    held           = 1'b0;
    while (items_sent < phase_end) begin
      // one long receiver hold-off while words keep coming, so the core backs up
      if (with_hold && !held && items_sent > phase_end - PHASE_ITEMS / 2) begin
        hold_left = HOLD_OFF_CYCLES;
        held      = 1'b1;
      end
      pick = $urandom_range(99);
      // with few survivors left a merge teaches little, reload instead
      if (sb.survivors < 2 && pick < 60) pick = 0;
      if (pick < 25) begin
        len_pick = $urandom_range(99);
        if (len_pick < 5)       send_initial_list($urandom_range(60, 70));
        else if (len_pick < 15) send_initial_list($urandom_range(13, 40));
        else                    send_initial_list($urandom_range(0, 12));
      end else if (pick < 60) begin
        send_merge_list();
      end else if (pick < 85) begin
        if (sb.filled > 0)
          repeat ($urandom_range(1, 4)) send_word(read_word(pick_index()));
      end else begin
        send_noise();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  // a pending hold-off wins over the random stall pattern
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.survivor_count = out_ch.survivor_count;
      got.read_file_id   = out_ch.read_file_id;
      got.read_valid     = out_ch.read_valid;
      got.overflow       = out_ch.overflow;
      sb.check_result(got);
    end
  end

  // ends the run if no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word accepted for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, sb.results_due.size());
    $display("tb_posting_list_intersection_core: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_ELEMENT;
    in_ch.file_id      <= '0;
    in_ch.has_element  <= 1'b0;
    in_ch.list_start   <= 1'b0;
    in_ch.list_end     <= 1'b0;
    in_ch.initial_list <= 1'b0;
    in_ch.read_index   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    wait_drained();

    // fill the whole ram and run past it, which raises the sticky overflow
    send_initial_list(70);

    run_phase(0, 0, 1'b1);
    wait_drained();
    run_phase(73, 0, 1'b0);
    wait_drained();
    run_phase(0, 73, 1'b0);
    wait_drained();
    run_phase(25, 25, 1'b0);
    wait_drained();

    // room for any stray word the core might still produce
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.drain_check();

    $display("run covered %0d words over %0d lists, %0d results checked, %0d real read-backs",
             items_sent, lists_sent, sb.checked, sb.reads_hit);
    $display("largest survivor set %0d, overflow raised %0d, %0d failures",
             sb.peak_survivors, sb.overflow_seen, sb.errors);
    if (sb.errors == 0)
      $display("tb_posting_list_intersection_core: done, clean");
    else
      $display("tb_posting_list_intersection_core: done, errors");
    $finish;
  end

endmodule
